// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the smoother.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in smoother checker");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in smoother checker");

`endif

// ----- rtl/pis_pkg.sv -----
// Package with the constants and control types of the polyline smoother.
`timescale 1ns / 1ps

package pis_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int PASS_W = 6;
  localparam logic [PASS_W-1:0] PASS_RESET = 6'd29;

  typedef struct packed {
    logic load;
    logic smooth;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/pis_if.sv -----
// Handshake interfaces for the point input and the smoothed result channels.
`timescale 1ns / 1ps

interface pis_point_if #(
  parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          is_last_point;

  modport source (output valid, output point_x, output point_y, output is_last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input is_last_point,
                output ready);
endinterface

interface pis_result_if #(
  parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] smooth_x;
  logic signed [COORD_WIDTH-1:0] smooth_y;
  logic                          is_last_result;
  logic                          empty_result;

  modport source (output valid, output smooth_x, output smooth_y, output is_last_result,
                  output empty_result, input ready);
  modport sink (input valid, input smooth_x, input smooth_y, input is_last_result,
                input empty_result, output ready);
endinterface

// ----- rtl/pis_cell.sv -----
// One cell of the point chain: holds a point, averages with neighbors, shifts out.
`timescale 1ns / 1ps

module pis_cell #(
  parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF,
  parameter int IDX         = 0,
  parameter int IW          = 6,
  parameter int CNTW        = 7
) (
  input  logic                          clk,
  input  pis_pkg::cell_ctl_t            ctl,
  input  logic [IW-1:0]                 load_idx,
  input  logic [CNTW-1:0]               count,
  input  logic signed [COORD_WIDTH-1:0] load_x,
  input  logic signed [COORD_WIDTH-1:0] load_y,
  input  logic signed [COORD_WIDTH-1:0] left_x,
  input  logic signed [COORD_WIDTH-1:0] left_y,
  input  logic signed [COORD_WIDTH-1:0] right_x,
  input  logic signed [COORD_WIDTH-1:0] right_y,
  output logic signed [COORD_WIDTH-1:0] x,
  output logic signed [COORD_WIDTH-1:0] y
);

  localparam int SW = COORD_WIDTH + 2;
  localparam int NR = 2 * ((SW + 1) / 2);
  localparam logic [NR-1:0] RECIP3 = {(NR / 2){2'b01}};

  function automatic logic signed [COORD_WIDTH-1:0] mean(input logic signed [SW-1:0] s,
                                                          input logic three);
    logic             neg;
    logic [SW-1:0]    mag;
    logic [SW+NR-1:0] prod;
    logic [SW-1:0]    q;
    logic [SW-1:0]    rem;
    neg  = s[SW-1];
    mag  = neg ? (~$unsigned(s) + SW'(1)) : $unsigned(s);
    prod = (SW + NR)'(mag) * (SW + NR)'(RECIP3);
    if (three) begin
      q   = prod[SW+NR-1:NR];
      rem = mag - (q + (q << 1));
      if (rem >= SW'(3)) begin
        q = q + SW'(1);
      end
    end else begin
      q = mag >> 1;
    end
    mean = neg ? COORD_WIDTH'(~q + SW'(1)) : COORD_WIDTH'(q);
  endfunction

  localparam logic HAS_LEFT = (IDX != 0);

  logic                 has_right;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;

  assign has_right = (CNTW'(IDX + 1) != count);

  always_comb begin
    sum_x = SW'(x);
    sum_y = SW'(y);
    if (HAS_LEFT) begin
      sum_x = sum_x + SW'(left_x);
      sum_y = sum_y + SW'(left_y);
    end
    if (has_right) begin
      sum_x = sum_x + SW'(right_x);
      sum_y = sum_y + SW'(right_y);
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.load && (load_idx == IW'(IDX))) begin
      x <= load_x;
      y <= load_y;
    end else if (ctl.smooth) begin
      x <= mean(sum_x, HAS_LEFT && has_right);
      y <= mean(sum_y, HAS_LEFT && has_right);
    end else if (ctl.shift) begin
      x <= right_x;
      y <= right_y;
    end
  end

endmodule

// ----- rtl/pis_ctrl.sv -----
// Sequencer for loading, smoothing passes and the output of the point chain.
`timescale 1ns / 1ps

module pis_ctrl #(
  parameter int MAX_POINTS = pis_pkg::MAX_POINTS_DEF,
  parameter int IW         = 6,
  parameter int CNTW       = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_last,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_last,
  output logic                       out_empty,
  input  logic [pis_pkg::PASS_W-1:0] pass_count,
  output pis_pkg::cell_ctl_t         ctl,
  output logic [IW-1:0]              load_idx,
  output logic [CNTW-1:0]            count
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SMOOTH,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic                       empty;
  logic [pis_pkg::PASS_W-1:0] passes_left;
  logic                       in_xfer;
  logic                       out_xfer;
  logic                       full;
  logic [CNTW-1:0]            count_next;

  assign in_ready   = (state == ST_LOAD);
  assign out_valid  = (state == ST_EMIT);
  assign out_empty  = empty;
  assign out_last   = empty || (count == CNTW'(1));
  assign in_xfer    = in_valid && in_ready;
  assign out_xfer   = out_valid && out_ready;
  assign full       = (count == CNTW'(MAX_POINTS));
  assign count_next = full ? count : count + CNTW'(1);
  assign load_idx   = count[IW-1:0];

  assign ctl.load   = in_xfer && !full;
  assign ctl.smooth = (state == ST_SMOOTH);
  assign ctl.shift  = out_xfer && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      empty       <= 1'b0;
      passes_left <= '0;
      count       <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (!in_last) begin
              count <= count_next;
            end else if ((count_next <= CNTW'(2)) || (pass_count == '0)) begin
              count <= '0;
              empty <= 1'b1;
              state <= ST_EMIT;
            end else begin
              count       <= count_next;
              empty       <= 1'b0;
              passes_left <= pass_count;
              state       <= ST_SMOOTH;
            end
          end
        end
        ST_SMOOTH: begin
          passes_left <= passes_left - pis_pkg::PASS_W'(1);
          if (passes_left == pis_pkg::PASS_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (out_last) begin
              count <= '0;
              empty <= 1'b0;
              state <= ST_LOAD;
            end else begin
              count <= count - CNTW'(1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/polyline_iterated_smoother.sv -----
// Top level of the iterated three-point polyline smoother built as a chain of cells.
//
//   channel   direction  transfer carries
//   points    in         point_x, point_y, is_last_point
//   results   out        smooth_x, smooth_y, is_last_result, empty_result
//   cfg       in         pass_count write (cfg_we, cfg_data)
//
// Points load at one per cycle, one per cell. After the last point all cells run
// pass_count smoothing passes at once, one per cycle, then shift one result out
// per transfer; two points or fewer, or pass_count 0, give one empty result.
// No points are accepted from the last point until the final result transfer.
// Reset clears the sequencer and sets pass_count to 29; cells need no clearing.
`timescale 1ns / 1ps

module polyline_iterated_smoother #(
  parameter int MAX_POINTS  = pis_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  pis_point_if.sink                  points,
  pis_result_if.source               results,
  input  logic                       cfg_we,
  input  logic [pis_pkg::PASS_W-1:0] cfg_data
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  logic [pis_pkg::PASS_W-1:0]    pass_count;
  pis_pkg::cell_ctl_t            ctl;
  logic [IW-1:0]                 load_idx;
  logic [CNTW-1:0]               count;
  logic                          empty;
  logic signed [COORD_WIDTH-1:0] cx [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] cy [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] lx [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] ly [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] rx [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] ry [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= pis_pkg::PASS_RESET;
    end else if (cfg_we) begin
      pass_count <= cfg_data;
    end
  end

  pis_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .IW        (IW),
    .CNTW      (CNTW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_last   (points.is_last_point),
    .in_ready  (points.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_last  (results.is_last_result),
    .out_empty (empty),
    .pass_count(pass_count),
    .ctl       (ctl),
    .load_idx  (load_idx),
    .count     (count)
  );

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign lx[i] = '0;
      assign ly[i] = '0;
    end else begin : g_left
      assign lx[i] = cx[i-1];
      assign ly[i] = cy[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_right_end
      assign rx[i] = '0;
      assign ry[i] = '0;
    end else begin : g_right
      assign rx[i] = cx[i+1];
      assign ry[i] = cy[i+1];
    end

    pis_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .IDX        (i),
      .IW         (IW),
      .CNTW       (CNTW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .load_idx(load_idx),
      .count   (count),
      .load_x  (points.point_x),
      .load_y  (points.point_y),
      .left_x  (lx[i]),
      .left_y  (ly[i]),
      .right_x (rx[i]),
      .right_y (ry[i]),
      .x       (cx[i]),
      .y       (cy[i])
    );
  end

  assign results.empty_result = empty;
  assign results.smooth_x     = empty ? '0 : cx[0];
  assign results.smooth_y     = empty ? '0 : cy[0];

endmodule

// ----- rtl/pis_checker.sv -----
// Port-level checker for the polyline smoother, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pis_checker #(
  parameter int COORD_WIDTH = pis_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic                          out_last,
  input logic                          out_empty
);

  `ASSERT_SAME(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ASSERT_SAME(a_empty_is_last, clk, rst, out_valid && out_empty, out_last)
  `ASSERT_SAME(a_empty_zero, clk, rst, out_valid && out_empty, (out_x == '0) && (out_y == '0))
  `ASSERT_NEXT(a_load_continues, clk, rst, in_valid && in_ready && !in_last, in_ready)
  `ASSERT_NEXT(a_back_to_load, clk, rst, out_valid && out_ready && out_last, in_ready)

endmodule

bind polyline_iterated_smoother pis_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_pis_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (points.valid),
  .in_ready (points.ready),
  .in_last  (points.is_last_point),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_x    (results.smooth_x),
  .out_y    (results.smooth_y),
  .out_last (results.is_last_result),
  .out_empty(results.empty_result)
);
